/* hdl/scb_pkg.sv */
// ---------------------------------------------------------------------------
// scb_pkg
// shared types and constants of the strip cluster builder
// ---------------------------------------------------------------------------
package scb_pkg;

    // item opcodes carried in tuser
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_CLOSE = 2'd2;

    // register select, bit 2 of the byte address
    localparam logic REG_CUT_SEED = 1'b0;
    localparam logic REG_CUT_ADJ  = 1'b1;

    localparam logic [7:0] CUT_SEED_RST = 8'd80;
    localparam logic [7:0] CUT_ADJ_RST  = 8'd48;

    localparam int SAMPLE_W = 8;   // one raw adc sample
    localparam int SUM_W    = 10;  // one summed sample
    localparam int WINDOW   = 3;   // strips summed around the best strip

    // per-beat control toward the window tracker
    typedef struct packed {
        logic push;     // strip taken into the cluster
        logic capture;  // strip becomes the best-sum strip
    } t_win_ctl;

endpackage

/* hdl/strip_cluster_builder.sv */
// ---------------------------------------------------------------------------
// strip_cluster_builder
// grows one strip cluster from adjacent strips and reports seed and sums
// ---------------------------------------------------------------------------
//  channel   dir  handshake                    contents
//  s_axis    in   tvalid/tready                one item: start, add or close
//  m_axis    out  tvalid/tready                one result beat per item
//  apb       in   psel/penable/pwrite, pready  cut_seed at 0x0, cut_adjacent at 0x4
//
//  one beat per cycle sustained while m_axis accepts; each beat passes through the
//  input register and then the result register
//  the cluster state sits behind the input register and is updated in the
//  same cycle the beat moves on, so the next beat already sees it
//  a stalled m_axis holds the result register and then the input register;
//  s_axis tready drops only when both are occupied
//  synchronous active-low reset clears control state and loads the cut
//  defaults; no clearing pass, the first beat may follow reset directly
// ---------------------------------------------------------------------------
module strip_cluster_builder #(
    parameter int MAX_STRIPS   = 32,
    parameter int SAMPLE_COUNT = 6,
    localparam int S_TW = ((63 + 8 * SAMPLE_COUNT + 7) / 8) * 8,
    localparam int M_TW = ((34 + 10 * SAMPLE_COUNT + 7) / 8) * 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // input items
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // sensor_id[15:0] u_side[16] cell_id[26:17] max_sample[34:27]
    // noise[46:35] digit_index[62:47] samples_packed[63+:8*SAMPLE_COUNT], zero pad
    input  logic [S_TW-1:0]  s_axis_tdata,
    // opcode[1:0]
    input  logic [1:0]       s_axis_tuser,
    // results
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // accepted[0] store_full[1] good[2] empty_cluster[3] cluster_size[9:4]
    // seed_index[25:10] seed_peak[33:26] summed_samples[34+:10*SAMPLE_COUNT], zero pad
    output logic [M_TW-1:0]  m_axis_tdata,
    // configuration
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import scb_pkg::*;

    localparam int CNT_W    = $clog2(MAX_STRIPS + 1);
    localparam int POS_W    = $clog2(MAX_STRIPS);
    localparam int PK_W     = 8 * SAMPLE_COUNT;
    localparam int SUMS_W   = 10 * SAMPLE_COUNT;
    localparam int SUMALL_W = $clog2(SAMPLE_COUNT * 255 + 1);

    // ---------------- configuration registers ----------------
    logic [7:0] r_cut_seed;
    logic [7:0] r_cut_adj;
    logic       w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cut_seed <= CUT_SEED_RST;
            r_cut_adj  <= CUT_ADJ_RST;
        end else if (w_cfg_wr) begin
            // only bit 2 selects; lower address bits are ignored
            if (paddr[2] == REG_CUT_ADJ) begin
                r_cut_adj <= pwdata[7:0];
            end else begin
                r_cut_seed <= pwdata[7:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_CUT_SEED) ? {24'b0, r_cut_seed} : {24'b0, r_cut_adj};

    // ---------------- input register ----------------
    logic            r_in_valid;
    logic [1:0]      r_in_op;
    logic [S_TW-1:0] r_in_data;
    logic            r_out_valid;
    logic [M_TW-1:0] r_out_data;
    logic            w_adv;

    // beat in the input register moves on when the result register frees up
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_op   <= s_axis_tuser;
            r_in_data <= s_axis_tdata;
        end
    end

    // field split of the held beat
    logic [15:0]     w_sensor;
    logic            w_side;
    logic [9:0]      w_cell;
    logic [7:0]      w_peak;
    logic [11:0]     w_noise;
    logic [15:0]     w_digit;
    logic [PK_W-1:0] w_samples;

    assign w_sensor  = r_in_data[15:0];
    assign w_side    = r_in_data[16];
    assign w_cell    = r_in_data[26:17];
    assign w_peak    = r_in_data[34:27];
    assign w_noise   = r_in_data[46:35];
    assign w_digit   = r_in_data[62:47];
    assign w_samples = r_in_data[63 +: PK_W];

    // ---------------- cluster state ----------------
    logic [15:0]         r_sensor;
    logic                r_side;
    logic [CNT_W-1:0]    r_count;
    logic [9:0]          r_last_cell;
    logic                r_seed_valid;
    logic [7:0]          r_seed_max;
    logic [11:0]         r_seed_noise;
    logic [15:0]         r_seed_digit;
    logic [SUMALL_W-1:0] r_best_sum;
    logic [POS_W-1:0]    r_best_pos;

    // ---------------- add decision ----------------
    logic                w_adj_pass;
    logic                w_seed_pass;
    logic                w_match;
    logic                w_next_cell;
    logic                w_cand;
    logic                w_full;
    logic                w_take;
    logic                w_reject_full;
    logic [SUMALL_W-1:0] w_strip_sum;
    logic                w_new_best;
    logic                w_new_seed;
    logic                w_is_add;
    logic                w_is_start;
    logic                w_is_close;

    scb_ratio u_adj_cut (
        .i_peak  (w_peak),
        .i_noise (w_noise),
        .i_cut   (r_cut_adj),
        .o_pass  (w_adj_pass)
    );

    scb_ratio u_seed_cut (
        .i_peak  (r_seed_max),
        .i_noise (r_seed_noise),
        .i_cut   (r_cut_seed),
        .o_pass  (w_seed_pass)
    );

    assign w_is_start = (r_in_op == OP_START);
    assign w_is_add   = (r_in_op == OP_ADD);
    assign w_is_close = (r_in_op == OP_CLOSE);

    assign w_match     = (w_sensor == r_sensor) && (w_side == r_side);
    // no wrap: cell 1023 has no follower
    assign w_next_cell = ({1'b0, w_cell} == ({1'b0, r_last_cell} + 11'd1));
    assign w_cand      = w_is_add && w_match && w_adj_pass
                      && ((r_count == '0) || w_next_cell);
    assign w_full        = (r_count >= CNT_W'(MAX_STRIPS));
    assign w_take        = w_cand && !w_full;
    assign w_reject_full = w_cand && w_full;

    always_comb begin
        w_strip_sum = '0;
        for (int i = 0; i < SAMPLE_COUNT; i++) begin
            w_strip_sum = w_strip_sum + SUMALL_W'(w_samples[i*SAMPLE_W +: SAMPLE_W]);
        end
    end

    // first strip always becomes the best, later ones only with a larger sum
    assign w_new_best = w_take && ((w_strip_sum > r_best_sum) || (r_count == '0));
    // first strip with the largest peak is the seed
    assign w_new_seed = w_take && (!r_seed_valid || (w_peak > r_seed_max));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor     <= '0;
            r_side       <= 1'b0;
            r_count      <= '0;
            r_last_cell  <= '0;
            r_seed_valid <= 1'b0;
            r_seed_max   <= '0;
            r_seed_noise <= '0;
            r_seed_digit <= '0;
            r_best_sum   <= '0;
            r_best_pos   <= '0;
        end else if (w_adv) begin
            if (w_is_start) begin
                r_sensor     <= w_sensor;
                r_side       <= w_side;
                r_count      <= '0;
                r_last_cell  <= '0;
                r_seed_valid <= 1'b0;
                r_seed_max   <= '0;
                r_seed_noise <= '0;
                r_seed_digit <= '0;
                r_best_sum   <= '0;
                r_best_pos   <= '0;
            end else if (w_take) begin
                r_count     <= r_count + CNT_W'(1);
                r_last_cell <= w_cell;
                if (w_new_best) begin
                    r_best_sum <= w_strip_sum;
                    r_best_pos <= r_count[POS_W-1:0];
                end
                if (w_new_seed) begin
                    r_seed_valid <= 1'b1;
                    r_seed_max   <= w_peak;
                    r_seed_noise <= w_noise;
                    r_seed_digit <= w_digit;
                end
            end
        end
    end

    // ---------------- window tracker ----------------
    t_win_ctl          w_win_ctl;
    logic [SUMS_W-1:0] w_sums;

    assign w_win_ctl.push    = w_adv && w_take;
    assign w_win_ctl.capture = w_new_best;

    scb_window #(
        .MAX_STRIPS   (MAX_STRIPS),
        .SAMPLE_COUNT (SAMPLE_COUNT)
    ) u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_win_ctl),
        .i_samples  (w_samples),
        .i_count    (r_count),
        .i_best_pos (r_best_pos),
        .o_sums     (w_sums)
    );

    // ---------------- result register ----------------
    logic            w_close_full;   // close on a non-empty cluster
    logic [M_TW-1:0] n_out_data;

    assign w_close_full = w_is_close && (r_count != '0);

    always_comb begin
        n_out_data        = '0;
        n_out_data[0]     = w_take;
        n_out_data[1]     = w_reject_full;
        n_out_data[3]     = w_is_close && (r_count == '0);
        if (w_close_full) begin
            n_out_data[2]     = r_seed_valid && (r_seed_max != '0) && w_seed_pass;
            n_out_data[9:4]   = 6'(r_count);
            n_out_data[25:10] = r_seed_valid ? r_seed_digit : '0;
            n_out_data[33:26] = r_seed_valid ? r_seed_max : '0;
            n_out_data[34 +: SUMS_W] = w_sums;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_STRIPS))
        else $error("strip count beyond store depth");

    a_take_xor_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("add both taken and refused as full");

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_is_start) |=> (r_count == '0) && !r_seed_valid)
        else $error("start beat did not clear the cluster");

    a_seed_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> r_seed_valid)
        else $error("non-empty cluster without a seed");

    a_take_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_take) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("taken strip not counted");

endmodule

/* hdl/scb_ratio.sv */
// ---------------------------------------------------------------------------
// scb_ratio
// signal-to-noise cut: peak * 256 >= cut * noise, exact integer compare
// ---------------------------------------------------------------------------
module scb_ratio (
    input  logic [7:0]  i_peak,
    input  logic [11:0] i_noise,
    input  logic [7:0]  i_cut,
    output logic        o_pass
);
    logic [19:0] w_lhs;
    logic [19:0] w_rhs;

    assign w_lhs  = {4'b0, i_peak, 8'b0};
    assign w_rhs  = 20'(i_cut) * 20'(i_noise);
    assign o_pass = (w_lhs >= w_rhs);

endmodule

/* hdl/scb_window.sv */
// ---------------------------------------------------------------------------
// scb_window
// keeps the strips needed for the three-strip sum and adds them on close
// ---------------------------------------------------------------------------
module scb_window #(
    parameter int MAX_STRIPS   = 32,
    parameter int SAMPLE_COUNT = 6,
    localparam int CNT_W = $clog2(MAX_STRIPS + 1),
    localparam int POS_W = $clog2(MAX_STRIPS),
    localparam int PK_W  = 8 * SAMPLE_COUNT,
    localparam int SUMS_W = 10 * SAMPLE_COUNT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  scb_pkg::t_win_ctl   i_ctl,
    input  logic [PK_W-1:0]     i_samples,
    input  logic [CNT_W-1:0]    i_count,
    input  logic [POS_W-1:0]    i_best_pos,
    output logic [SUMS_W-1:0]   o_sums
);
    import scb_pkg::*;

    // last three strips taken, s0 newest
    logic [PK_W-1:0] r_s0, r_s1, r_s2;
    // strips around the best strip: two before, itself, two after
    logic [PK_W-1:0] r_bm2, r_bm1, r_b0, r_bp1, r_bp2;
    // strips taken after the best so far (saturates at two)
    logic [1:0]      r_after;

    logic [PK_W-1:0] w_a, w_b, w_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_after <= 2'd0;
        end else if (i_ctl.push) begin
            if (i_ctl.capture) begin
                r_after <= 2'd0;
            end else if (r_after != 2'd2) begin
                r_after <= r_after + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_s0 <= i_samples;
            r_s1 <= r_s0;
            r_s2 <= r_s1;
            if (i_ctl.capture) begin
                r_bm2 <= r_s1;
                r_bm1 <= r_s0;
                r_b0  <= i_samples;
            end else if (r_after == 2'd0) begin
                r_bp1 <= i_samples;
            end else if (r_after == 2'd1) begin
                r_bp2 <= i_samples;
            end
        end
    end

    // pick the three strips of the window, clamped inward at the ends
    always_comb begin
        w_a = r_s0;
        w_b = '0;
        w_c = '0;
        priority if (i_count > CNT_W'(WINDOW)) begin
            priority if (i_best_pos == '0) begin
                w_a = r_b0;
                w_b = r_bp1;
                w_c = r_bp2;
            end else if (CNT_W'(i_best_pos) == i_count - CNT_W'(1)) begin
                w_a = r_bm2;
                w_b = r_bm1;
                w_c = r_b0;
            end else begin
                w_a = r_bm1;
                w_b = r_b0;
                w_c = r_bp1;
            end
        end else begin
            w_a = r_s0;
            w_b = (i_count >= CNT_W'(2)) ? r_s1 : '0;
            w_c = (i_count >= CNT_W'(3)) ? r_s2 : '0;
        end
    end

    always_comb begin
        for (int i = 0; i < SAMPLE_COUNT; i++) begin
            o_sums[i*SUM_W +: SUM_W] = SUM_W'(w_a[i*SAMPLE_W +: SAMPLE_W])
                                     + SUM_W'(w_b[i*SAMPLE_W +: SAMPLE_W])
                                     + SUM_W'(w_c[i*SAMPLE_W +: SAMPLE_W]);
        end
    end

endmodule

/* tb/scb_result_checker.sv */
// ---------------------------------------------------------------------------
// scb_result_checker
// watches the item, result and register channels of the strip cluster
// builder, predicts each result beat and compares it field by field
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module scb_result_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  logic [111:0]  i_in_data,
    input  logic [1:0]    i_in_op,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  logic [95:0]   i_out_data,
    input  logic          i_psel,
    input  logic          i_penable,
    input  logic          i_pwrite,
    input  logic          i_pready,
    input  logic [2:0]    i_paddr,
    input  logic [31:0]   i_pwdata,
    output int            o_errors,
    output int            o_pending,
    output int            o_results,
    output int            o_closes,
    output int            o_good,
    output int            o_full
);
    import scb_pkg::*;

    localparam int MAX_STRIPS = 32;
    localparam int SAMPLES    = 6;

    // same layout as s_axis_tdata, highest field first
    typedef struct packed {
        logic [47:0] samples;
        logic [15:0] digit;
        logic [11:0] noise;
        logic [7:0]  peak;
        logic [9:0]  strip_no;
        logic        side;
        logic [15:0] sensor;
    } t_strip_beat;

    // same layout as m_axis_tdata, highest field first
    typedef struct packed {
        logic [59:0] sums;
        logic [7:0]  seed_peak;
        logic [15:0] seed_index;
        logic [5:0]  size;
        logic        empty;
        logic        good;
        logic        store_full;
        logic        accepted;
    } t_cluster_result;

    logic [7:0]  cut_seed;
    logic [7:0]  cut_adj;
    logic [15:0] clu_sensor;
    logic        clu_side;
    int          n_strips;
    logic [9:0]  last_cell;
    logic        seed_valid;
    logic [7:0]  seed_max;
    logic [11:0] seed_noise;
    logic [15:0] seed_digit;
    int          best_sum;
    int          best_pos;
    logic [47:0] strip_store [MAX_STRIPS];

    t_cluster_result expected_results [$];

    function automatic void empty_cluster_state();
        n_strips   = 0;
        last_cell  = '0;
        seed_valid = 1'b0;
        seed_max   = '0;
        seed_noise = '0;
        seed_digit = '0;
        best_sum   = 0;
        best_pos   = 0;
    endfunction

    // advance the cluster by one item and return the beat it must produce
    function automatic t_cluster_result grow_cluster(input logic [1:0] op,
                                                     input t_strip_beat s);
        t_cluster_result r;
        int sum;
        int lo;
        int hi;
        int centre;
        int acc;
        r = '0;
        unique case (op)
            OP_START: begin
                empty_cluster_state();
                clu_sensor = s.sensor;
                clu_side   = s.side;
            end
            OP_ADD: begin
                // ratio cut as peak*256 >= cut*noise, no wrap past cell 1023
                if (s.sensor == clu_sensor && s.side == clu_side &&
                    int'(s.peak) * 256 >= int'(cut_adj) * int'(s.noise) &&
                    (n_strips == 0 || int'(s.strip_no) == int'(last_cell) + 1)) begin
                    if (n_strips >= MAX_STRIPS) begin
                        r.store_full = 1'b1;
                    end else begin
                        sum = 0;
                        for (int i = 0; i < SAMPLES; i++)
                            sum += int'(s.samples[8*i +: 8]);
                        if (sum > best_sum) begin
                            best_sum = sum;
                            best_pos = n_strips;
                        end
                        // first strip with the largest peak stays the seed
                        if (!seed_valid || s.peak > seed_max) begin
                            seed_valid = 1'b1;
                            seed_max   = s.peak;
                            seed_noise = s.noise;
                            seed_digit = s.digit;
                        end
                        strip_store[n_strips] = s.samples;
                        n_strips++;
                        last_cell  = s.strip_no;
                        r.accepted = 1'b1;
                    end
                end
            end
            OP_CLOSE: begin
                if (n_strips == 0) begin
                    r.empty = 1'b1;
                end else begin
                    lo = 0;
                    hi = n_strips - 1;
                    if (n_strips > WINDOW) begin
                        // three strips around the best sum, kept inside the cluster
                        centre = best_pos;
                        if (centre == 0)
                            centre = 1;
                        if (centre >= n_strips - 1)
                            centre = n_strips - 2;
                        lo = centre - 1;
                        hi = centre + 1;
                    end
                    for (int i = 0; i < SAMPLES; i++) begin
                        acc = 0;
                        for (int k = lo; k <= hi; k++)
                            acc += int'(strip_store[k][8*i +: 8]);
                        r.sums[10*i +: 10] = acc[9:0];
                    end
                    r.good = seed_valid && seed_max > 0 &&
                             int'(seed_max) * 256 >= int'(cut_seed) * int'(seed_noise);
                    r.size       = n_strips[5:0];
                    r.seed_index = seed_valid ? seed_digit : '0;
                    r.seed_peak  = seed_valid ? seed_max : '0;
                end
            end
            default: begin
                // spare opcode, all-zero beat
            end
        endcase
        return r;
    endfunction

    task automatic report_result(input string why, input t_cluster_result want,
                                 input t_cluster_result got);
        if (o_errors < 10) begin
            $display("%0t: %s", $time, why);
            $display("  expected acc %0d full %0d good %0d empty %0d size %0d",
                     want.accepted, want.store_full, want.good, want.empty, want.size);
            $display("           seed %04h peak %0d sums %015h",
                     want.seed_index, want.seed_peak, want.sums);
            $display("  actual   acc %0d full %0d good %0d empty %0d size %0d",
                     got.accepted, got.store_full, got.good, got.empty, got.size);
            $display("           seed %04h peak %0d sums %015h",
                     got.seed_index, got.seed_peak, got.sums);
        end
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_cluster_result got;
        t_cluster_result want;
        if (!i_rst_n) begin
            cut_seed   = CUT_SEED_RST;
            cut_adj    = CUT_ADJ_RST;
            clu_sensor = '0;
            clu_side   = 1'b0;
            empty_cluster_state();
            expected_results.delete();
            o_errors  = 0;
            o_results = 0;
            o_closes  = 0;
            o_good    = 0;
            o_full    = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_CUT_SEED)
                    cut_seed = i_pwdata[7:0];
                else
                    cut_adj = i_pwdata[7:0];
            end
            // results leave through the input and result registers after their item, so match them first
            if (i_out_valid && i_out_ready) begin
                got = t_cluster_result'(i_out_data[93:0]);
                o_results++;
                if (expected_results.size() == 0) begin
                    report_result("result beat with nothing expected", '0, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got.accepted !== want.accepted || got.store_full !== want.store_full ||
                        got.good !== want.good || got.empty !== want.empty ||
                        got.size !== want.size || got.seed_index !== want.seed_index ||
                        got.seed_peak !== want.seed_peak || got.sums !== want.sums)
                        report_result("result beat mismatch", want, got);
                end
            end
            if (i_in_valid && i_in_ready) begin
                want = grow_cluster(i_in_op, t_strip_beat'(i_in_data[110:0]));
                expected_results.insert(expected_results.size(), want);
                if (i_in_op == OP_CLOSE && !want.empty)
                    o_closes++;
                if (want.good)
                    o_good++;
                if (want.store_full)
                    o_full++;
            end
        end
        o_pending = expected_results.size();
    end

endmodule

/* tb/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the strip cluster builder; a checker module
// beside the block predicts every result beat and counts mismatches
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import scb_pkg::*;

    localparam int S_TW = 112;
    localparam int M_TW = 96;
    localparam logic [1:0] OP_SPARE = 2'd3;   // not decoded by the block
    localparam int PHASE_ITEMS = 180;          // random items per cut setting

    // same layout as s_axis_tdata, highest field first
    typedef struct packed {
        logic [47:0] samples;
        logic [15:0] digit;
        logic [11:0] noise;
        logic [7:0]  peak;
        logic [9:0]  strip_no;
        logic        side;
        logic [15:0] sensor;
    } t_strip_item;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            s_axis_tvalid = 1'b0;
    logic            s_axis_tready;
    // sensor_id, u_side, cell_id, max_sample, noise, digit_index, samples_packed, pad
    logic [S_TW-1:0] s_axis_tdata = '0;
    // opcode
    logic [1:0]      s_axis_tuser = OP_START;
    logic            m_axis_tvalid;
    logic            m_axis_tready = 1'b0;
    // accepted, store_full, good, empty_cluster, cluster_size, seed_index,
    // seed_peak, summed_samples, pad
    logic [M_TW-1:0] m_axis_tdata;
    logic            psel = 1'b0;
    logic            penable = 1'b0;
    logic            pwrite = 1'b0;
    logic [2:0]      paddr = '0;
    logic [31:0]     pwdata = '0;
    logic [31:0]     prdata;
    logic            pready;

    int src_idle_pct = 27;    // chance per cycle that the sender holds back
    int snk_idle_pct = 45;    // chance per cycle that the receiver stalls
    int snk_hold_cycles = 0;  // set to force one long receiver stall
    int items_sent = 0;
    int adj_cut_now = CUT_ADJ_RST;  // steers noise so most adds pass the cut

    int errors;
    int pending;
    int results;
    int closes;
    int goods;
    int fulls;

    strip_cluster_builder i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    scb_result_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_in_op     (s_axis_tuser),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_pready    (pready),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_results   (results),
        .o_closes    (closes),
        .o_good      (goods),
        .o_full      (fulls)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // receiver: random stalls, or one long hold-off when asked
    initial begin
        forever begin
            @(negedge i_clk);
            if (snk_hold_cycles > 0) begin
                m_axis_tready <= 1'b0;
                repeat (snk_hold_cycles) @(negedge i_clk);
                snk_hold_cycles = 0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
            end
        end
    end

    function automatic t_strip_item strip_beat(input logic [15:0] sensor, input logic side,
                                               input logic [9:0] strip_no,
                                               input logic [7:0] peak,
                                               input logic [11:0] noise,
                                               input logic [15:0] digit,
                                               input logic [47:0] samples);
        t_strip_item s;
        s.sensor   = sensor;
        s.side     = side;
        s.strip_no = strip_no;
        s.peak     = peak;
        s.noise    = noise;
        s.digit    = digit;
        s.samples  = samples;
        return s;
    endfunction

    // random strip; noise mostly kept low enough to pass the adjacent cut
    function automatic t_strip_item random_strip();
        t_strip_item s;
        int roll;
        int limit;
        s.sensor   = 16'($urandom);
        s.side     = 1'($urandom);
        s.strip_no = 10'($urandom);
        s.digit    = 16'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 10)
            s.peak = 8'd0;
        else if (roll < 20)
            s.peak = 8'hff;
        else
            s.peak = 8'($urandom);
        if ($urandom_range(0, 99) < 75) begin
            limit = (adj_cut_now == 0) ? 4095 : (int'(s.peak) * 256) / adj_cut_now;
            if (limit > 4095)
                limit = 4095;
            s.noise = 12'($urandom_range(0, limit));
        end else begin
            s.noise = 12'($urandom);
        end
        roll = $urandom_range(0, 99);
        if (roll < 10)
            s.samples = '0;
        else if (roll < 15)
            s.samples = '1;
        else
            s.samples = {16'($urandom), 32'($urandom)};
        return s;
    endfunction

    // offer one beat, with a random gap in front; returns at the falling
    // edge after the beat went in, tvalid still high
    task automatic send_beat(input logic [1:0] op, input t_strip_item s);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        s_axis_tdata  <= {1'b0, s};
        s_axis_tuser  <= op;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        items_sent++;
    endtask

    // stop offering and wait until every result beat has come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
        @(negedge i_clk);
    endtask

    task automatic apb_write(input logic reg_sel, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= {24'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_cuts(input logic [7:0] seed_cut, input logic [7:0] adj_cut);
        apb_write(REG_CUT_SEED, seed_cut);
        apb_write(REG_CUT_ADJ, adj_cut);
        adj_cut_now = adj_cut;
    endtask

    // edge cases at the reset cuts (seed 80/256, adjacent 48/256)
    task automatic run_directed();
        // close straight after reset: empty cluster
        send_beat(OP_CLOSE, '0);
        send_beat(OP_SPARE, '1);
        // the reset cluster is sensor 0, V side, so this add is taken
        send_beat(OP_ADD, strip_beat(16'h0000, 1'b0, 10'd5, 8'd100, 12'd16, 16'd7,
                                     48'h060504030201));
        send_beat(OP_CLOSE, '0);
        send_beat(OP_START, strip_beat(16'hffff, 1'b1, '0, '0, '0, '0, '0));
        // sensor and side mismatch
        send_beat(OP_ADD, strip_beat(16'hfffe, 1'b1, 10'd1022, 8'hff, 12'd0, 16'd1, '1));
        send_beat(OP_ADD, strip_beat(16'hffff, 1'b0, 10'd1022, 8'hff, 12'd0, 16'd2, '1));
        // all-ones strip with zero noise, then exactly at the adjacent cut
        send_beat(OP_ADD, strip_beat(16'hffff, 1'b1, 10'd1022, 8'hff, 12'd0, 16'hffff, '1));
        send_beat(OP_ADD, strip_beat(16'hffff, 1'b1, 10'd1023, 8'd48, 12'd256, 16'd1, '1));
        // no follower for cell 1023
        send_beat(OP_ADD, strip_beat(16'hffff, 1'b1, 10'd0, 8'hff, 12'd0, 16'd3, '1));
        send_beat(OP_CLOSE, '0);
        // zero-peak seed, then one below the cut
        send_beat(OP_START, strip_beat(16'h1234, 1'b0, '0, '0, '0, '0, '0));
        send_beat(OP_ADD, strip_beat(16'h1234, 1'b0, 10'd10, 8'd0, 12'd0, 16'd4, '0));
        send_beat(OP_ADD, strip_beat(16'h1234, 1'b0, 10'd11, 8'd47, 12'd256, 16'd5, '1));
        send_beat(OP_CLOSE, '0);
        // rising sums so the best strip is the last one; equal peaks keep the first seed
        send_beat(OP_ADD, strip_beat(16'h1234, 1'b0, 10'd11, 8'd90, 12'd40, 16'd6,
                                     48'h010101010101));
        send_beat(OP_ADD, strip_beat(16'h1234, 1'b0, 10'd12, 8'd90, 12'd16, 16'd8,
                                     48'h101010101010));
        send_beat(OP_ADD, strip_beat(16'h1234, 1'b0, 10'd13, 8'd60, 12'd16, 16'd9,
                                     48'h808080808080));
        send_beat(OP_ADD, strip_beat(16'h1234, 1'b0, 10'd14, 8'd20, 12'd4, 16'd10, '1));
        send_beat(OP_CLOSE, '0);
        // falling sums so the best strip is the first one
        send_beat(OP_START, strip_beat(16'h00ff, 1'b1, '0, '0, '0, '0, '0));
        send_beat(OP_ADD, strip_beat(16'h00ff, 1'b1, 10'd512, 8'd30, 12'd2000, 16'd11, '1));
        send_beat(OP_ADD, strip_beat(16'h00ff, 1'b1, 10'd513, 8'd200, 12'd20, 16'd12,
                                     48'h7f7f7f7f7f7f));
        send_beat(OP_ADD, strip_beat(16'h00ff, 1'b1, 10'd514, 8'd200, 12'd20, 16'd13,
                                     48'h3f3f3f3f3f3f));
        send_beat(OP_ADD, strip_beat(16'h00ff, 1'b1, 10'd515, 8'd10, 12'd20, 16'd14,
                                     48'h0f0f0f0f0f0f));
        send_beat(OP_CLOSE, '0);
    endtask

    // one well-formed cluster with random content, salted with bad strips
    task automatic run_one_cluster();
        logic [15:0] sensor;
        logic        side;
        logic [9:0]  next_no;
        int          len;
        int          roll;
        t_strip_item s;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            sensor = 16'h0000;
        else if (roll < 10)
            sensor = 16'hffff;
        else
            sensor = 16'($urandom);
        side = 1'($urandom);
        if ($urandom_range(0, 99) < 15)
            next_no = 10'd1023 - 10'($urandom_range(0, 5));
        else
            next_no = 10'($urandom);
        // long runs overflow the strip store
        len = ($urandom_range(0, 99) < 8) ? $urandom_range(30, 40) : $urandom_range(1, 8);
        roll = $urandom_range(0, 99);
        if (roll < 4)
            send_beat(OP_SPARE, random_strip());
        else if (roll < 8)
            send_beat(OP_CLOSE, random_strip());
        s = random_strip();
        s.sensor = sensor;
        s.side   = side;
        send_beat(OP_START, s);
        for (int k = 0; k < len; k++) begin
            s = random_strip();
            roll = $urandom_range(0, 99);
            if (roll < 97) begin
                s.sensor   = sensor;
                s.side     = side;
                s.strip_no = next_no;
            end
            if (roll < 85) begin
                next_no = next_no + 10'd1;
            end else if (roll < 89) begin
                s.sensor = sensor ^ (16'd1 << $urandom_range(0, 15));
            end else if (roll < 93) begin
                s.side = ~side;
            end else if (roll < 97) begin
                s.strip_no = next_no + 10'($urandom_range(1, 3));
            end
            send_beat(OP_ADD, s);
            if ($urandom_range(0, 99) < 5)
                send_beat(OP_CLOSE, random_strip());
        end
        send_beat(OP_CLOSE, random_strip());
    endtask

    task automatic run_clusters(input int stop_at);
        while (items_sent < stop_at)
            run_one_cluster();
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();

        for (int phase = 0; phase < 6; phase++) begin
            drain();
            // receiver-heavy stalls, then sender-heavy gaps, then full rate
            unique case (phase / 2)
                0: begin
                    src_idle_pct = 27;
                    snk_idle_pct = 45;
                end
                1: begin
                    src_idle_pct = 45;
                    snk_idle_pct = 27;
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                end
            endcase
            unique case (phase)
                0: set_cuts(8'd0, 8'd0);
                1: set_cuts(8'd255, 8'd255);
                2: set_cuts(8'($urandom), 8'($urandom));
                3: set_cuts(8'd255, 8'd0);
                4: set_cuts(8'd0, 8'd255);
                default: set_cuts(CUT_SEED_RST, CUT_ADJ_RST);
            endcase
            if (phase == 0) begin
                // receiver holds off while items keep coming, so the block backs up
                run_clusters(items_sent + PHASE_ITEMS / 2);
                snk_hold_cycles = 300;
            end else if (phase == 4) begin
                // sender waits for the pipeline to empty mid-stream
                run_clusters(items_sent + PHASE_ITEMS / 2);
                drain();
            end
            run_clusters(items_sent + PHASE_ITEMS / (phase == 0 || phase == 4 ? 2 : 1));
        end

        drain();
        repeat (10) @(posedge i_clk);
        $display("covered %0d items and %0d result beats over six cut settings", items_sent,
                 results);
        $display("%0d clusters closed (%0d good), %0d adds refused on a full store", closes,
                 goods, fulls);
        if (errors == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
